/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the 1-Wire master checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled during reset.
`define OWM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("owm assertion failed");

// Assert that an antecedent implies a consequent in the same cycle.
`define OWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("owm implication failed");

`endif

/* rtl/owm_pkg.sv */
// ----------------------------------------------------------------------------
// owm_pkg
// Types, command codes and slot timing constants of the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_W1   = 4'd2,
    PH_RST_W2   = 4'd3,
    PH_RST_TAIL = 4'd4,
    PH_W_LOW    = 4'd5,
    PH_W_REL    = 4'd6,
    PH_W_GAP    = 4'd7,
    PH_R_LOW    = 4'd8,
    PH_R_WAIT   = 4'd9,
    PH_R_TAIL   = 4'd10,
    PH_R_GAP    = 4'd11
  } phase_e;

  localparam int unsigned CntW = 9;
  localparam int unsigned BitW = 3;

  // Phase durations in microseconds
  localparam logic [CntW-1:0] T_RST_LOW  = 9'd485;
  localparam logic [CntW-1:0] T_RST_W1   = 9'd60;
  localparam logic [CntW-1:0] T_RST_W2   = 9'd240;
  localparam logic [CntW-1:0] T_RST_TAIL = 9'd240;
  localparam logic [CntW-1:0] T_W1_LOW   = 9'd6;
  localparam logic [CntW-1:0] T_W1_REL   = 9'd64;
  localparam logic [CntW-1:0] T_W0_LOW   = 9'd60;
  localparam logic [CntW-1:0] T_W0_REL   = 9'd10;
  localparam logic [CntW-1:0] T_R_LOW    = 9'd6;
  localparam logic [CntW-1:0] T_R_WAIT   = 9'd9;
  localparam logic [CntW-1:0] T_R_TAIL   = 9'd55;
  localparam logic [CntW-1:0] T_GAP      = 9'd2;
  localparam logic [BitW-1:0] LAST_BIT   = 3'd7;

  // Input item
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       bus_sample;
  } req_t;

  // Result item
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       device_present;
    logic [7:0] read_data;
    logic       cmd_rejected;
  } res_t;

endpackage

/* rtl/owm_if.sv */
// ----------------------------------------------------------------------------
// owm_req_if / owm_res_if
// Valid/ready channels for request and result transfers.
// ----------------------------------------------------------------------------
interface owm_req_if;
  logic            valid;
  logic            ready;
  owm_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface owm_res_if;
  logic            valid;
  logic            ready;
  owm_pkg::res_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/onewire_bus_master_top.sv */
// ----------------------------------------------------------------------------
// onewire_bus_master_top
// 1-Wire bus master timed by one-microsecond tick transfers.
//
//   channel  direction  contents
//   req_i    in         req_type, data_byte, bus_sample
//   res_o    out        drive_low, busy_res, done_res, device_present,
//                       read_data, cmd_rejected
//
// Every request transfer yields exactly one result, offered on the next cycle.
// Throughput is one request per cycle while results are taken; the sequencer
// update is a single combinational pass into the result register.
// The result register frees the request side: a request is taken whenever
// the result slot is empty or is being drained in the same cycle.
// A stalled result holds its slot and blocks further requests until taken.
// rst_ni clears the sequencer to idle with no device present.
// ----------------------------------------------------------------------------
module onewire_bus_master_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  owm_req_if.sink   req_i,
  owm_res_if.source res_o
);
  import owm_pkg::*;

  logic  step;
  logic  res_valid_q;
  res_t  res_d;
  res_t  res_q;

  // Take a request when the result slot is free or draining
  assign req_i.ready = !res_valid_q || res_o.ready;
  assign step        = req_i.valid && req_i.ready;

  owm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (req_i.data),
    .res_o  (res_d)
  );

  // Track result occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Capture result payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

endmodule

/* rtl/owm_seq.sv */
// ----------------------------------------------------------------------------
// owm_seq
// Phase sequencer: holds the bus timing state and computes one result per item.
// ----------------------------------------------------------------------------
module owm_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  owm_pkg::req_t  req_i,
  output owm_pkg::res_t  res_o
);
  import owm_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [BitW-1:0]   bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;
  logic              first_q, first_d;
  logic              present_q, present_d;
  logic [7:0]        last_read_q, last_read_d;
  logic              rejected;
  logic              done;

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      first_q     <= 1'b1;
      present_q   <= 1'b0;
      last_read_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      first_q     <= first_d;
      present_q   <= present_d;
      last_read_q <= last_read_d;
    end
  end

  // Start or reject a command, or advance the running sequence one microsecond
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    first_d     = first_q;
    present_d   = present_q;
    last_read_d = last_read_q;
    rejected    = 1'b0;
    done        = 1'b0;

    if (req_i.req_type != REQ_TICK) begin
      if (phase_q != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        unique case (req_e'(req_i.req_type))
          REQ_RESET: begin
            phase_d = PH_RST_LOW;
            cnt_d   = T_RST_LOW;
          end
          REQ_WRITE: begin
            shift_d = req_i.data_byte;
            bit_d   = '0;
            phase_d = PH_W_LOW;
            cnt_d   = req_i.data_byte[0] ? T_W1_LOW : T_W0_LOW;
          end
          REQ_READ: begin
            shift_d = '0;
            bit_d   = '0;
            phase_d = PH_R_LOW;
            cnt_d   = T_R_LOW;
          end
          REQ_TICK: begin
          end
        endcase
      end
    end else if (phase_q != PH_IDLE) begin
      if (cnt_q > CntW'(1)) begin
        cnt_d = cnt_q - CntW'(1);
      end else begin
        // Close the current phase
        unique case (phase_q)
          PH_RST_LOW: begin
            phase_d = PH_RST_W1;
            cnt_d   = T_RST_W1;
          end
          PH_RST_W1: begin
            first_d = req_i.bus_sample;
            phase_d = PH_RST_W2;
            cnt_d   = T_RST_W2;
          end
          PH_RST_W2: begin
            present_d = !first_q && req_i.bus_sample;
            phase_d   = PH_RST_TAIL;
            cnt_d     = T_RST_TAIL;
          end
          PH_RST_TAIL: begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
            done    = 1'b1;
          end
          PH_W_LOW: begin
            phase_d = PH_W_REL;
            cnt_d   = shift_q[0] ? T_W1_REL : T_W0_REL;
          end
          PH_W_REL: begin
            shift_d = {1'b0, shift_q[7:1]};
            phase_d = PH_W_GAP;
            cnt_d   = T_GAP;
          end
          PH_W_GAP: begin
            if (bit_q == LAST_BIT) begin
              phase_d = PH_IDLE;
              cnt_d   = '0;
              done    = 1'b1;
            end else begin
              bit_d   = bit_q + BitW'(1);
              phase_d = PH_W_LOW;
              cnt_d   = shift_q[0] ? T_W1_LOW : T_W0_LOW;
            end
          end
          PH_R_LOW: begin
            phase_d = PH_R_WAIT;
            cnt_d   = T_R_WAIT;
          end
          PH_R_WAIT: begin
            shift_d = {req_i.bus_sample, shift_q[7:1]};
            phase_d = PH_R_TAIL;
            cnt_d   = T_R_TAIL;
          end
          PH_R_TAIL: begin
            phase_d = PH_R_GAP;
            cnt_d   = T_GAP;
          end
          PH_R_GAP: begin
            if (bit_q == LAST_BIT) begin
              last_read_d = shift_q;
              phase_d     = PH_IDLE;
              cnt_d       = '0;
              done        = 1'b1;
            end else begin
              bit_d   = bit_q + BitW'(1);
              phase_d = PH_R_LOW;
              cnt_d   = T_R_LOW;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
          end
        endcase
      end
    end
  end

  // Build the result from the state after this item
  always_comb begin
    res_o.drive_low      = (phase_d == PH_RST_LOW) || (phase_d == PH_W_LOW) ||
                           (phase_d == PH_R_LOW);
    res_o.busy_res       = (phase_d != PH_IDLE);
    res_o.done_res       = done;
    res_o.device_present = present_d;
    res_o.read_data      = last_read_d;
    res_o.cmd_rejected   = rejected;
  end

endmodule

/* rtl/owm_checker.sv */
// ----------------------------------------------------------------------------
// owm_checker
// Port-level assertions for the 1-Wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module owm_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  logic          res_valid_i,
  input  logic          res_ready_i,
  input  owm_pkg::res_t res_data_i
);
  import owm_pkg::*;

  logic req_xfer;
  logic res_stall;

  assign req_xfer  = req_valid_i && req_ready_i;
  assign res_stall = res_valid_i && !res_ready_i;

  // A stalled result stays offered
  `OWM_ASSERT(a_res_hold, clk_i, rst_ni, res_stall |=> res_valid_i)

  // Every request transfer produces a result in the next cycle
  `OWM_ASSERT(a_req_to_res, clk_i, rst_ni, req_xfer |=> res_valid_i)

  // No request is taken while the result slot is blocked
  `OWM_ASSERT_IMP(a_no_overrun, clk_i, rst_ni, res_stall, !req_ready_i)

  // A finishing sequence is never still busy
  `OWM_ASSERT_IMP(a_done_idle, clk_i, rst_ni, res_valid_i && res_data_i.done_res,
                  !res_data_i.busy_res && !res_data_i.cmd_rejected)

  // A rejected command leaves the running sequence busy
  `OWM_ASSERT_IMP(a_reject_busy, clk_i, rst_ni,
                  res_valid_i && res_data_i.cmd_rejected, res_data_i.busy_res)

endmodule

bind onewire_bus_master_top owm_checker u_owm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

/* dv/onewire_bus_master_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_bus_master_top_tb
// Self-checking bench for the 1-Wire bus master. A cycle-level model of the
// sequencer runs alongside the block. Named tests cover idle ticks, reset
// and presence detection, byte writes, byte reads and commands that arrive
// while busy. A random phase then runs many command sequences with stray
// commands. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module onewire_bus_master_top_tb;
  import owm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  owm_req_if req_if ();
  owm_res_if res_if ();

  onewire_bus_master_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sequencer model state
  phase_e     m_phase;
  logic [8:0] m_cnt;
  logic [2:0] m_bit;
  logic [7:0] m_shift;
  logic       m_first;
  logic       m_present;
  logic [7:0] m_last_rd;

  res_t        status_q[$];
  int unsigned fail_cnt, cmd_cnt, seq_cnt, done_cnt, reject_cnt, xfer_cnt, item_cnt;
  int unsigned rx_stall;
  bit          rx_quiet, tx_quiet;

  // Advance the model by one request; return the status word it produces
  function automatic res_t sequencer_step(input req_t it);
    res_t r;
    logic done, rej;
    done = 1'b0;
    rej  = 1'b0;
    if (it.req_type != REQ_TICK) begin
      if (m_phase != PH_IDLE) begin
        rej = 1'b1;
      end else if (it.req_type == REQ_RESET) begin
        m_phase = PH_RST_LOW;
        m_cnt   = T_RST_LOW;
      end else if (it.req_type == REQ_WRITE) begin
        m_shift = it.data_byte;
        m_bit   = '0;
        m_phase = PH_W_LOW;
        m_cnt   = m_shift[0] ? T_W1_LOW : T_W0_LOW;
      end else begin
        m_shift = '0;
        m_bit   = '0;
        m_phase = PH_R_LOW;
        m_cnt   = T_R_LOW;
      end
    end else if (m_phase != PH_IDLE) begin
      if (m_cnt > 9'd1) begin
        m_cnt = m_cnt - 9'd1;
      end else begin
        case (m_phase)
          PH_RST_LOW: begin
            m_phase = PH_RST_W1;
            m_cnt   = T_RST_W1;
          end
          PH_RST_W1: begin
            m_first = it.bus_sample;
            m_phase = PH_RST_W2;
            m_cnt   = T_RST_W2;
          end
          PH_RST_W2: begin
            m_present = !m_first && it.bus_sample;
            m_phase   = PH_RST_TAIL;
            m_cnt     = T_RST_TAIL;
          end
          PH_RST_TAIL: begin
            m_phase = PH_IDLE;
            m_cnt   = '0;
            done    = 1'b1;
          end
          PH_W_LOW: begin
            m_phase = PH_W_REL;
            m_cnt   = m_shift[0] ? T_W1_REL : T_W0_REL;
          end
          PH_W_REL: begin
            m_shift = m_shift >> 1;
            m_phase = PH_W_GAP;
            m_cnt   = T_GAP;
          end
          PH_W_GAP: begin
            if (m_bit == LAST_BIT) begin
              m_phase = PH_IDLE;
              m_cnt   = '0;
              done    = 1'b1;
            end else begin
              m_bit   = m_bit + 3'd1;
              m_phase = PH_W_LOW;
              m_cnt   = m_shift[0] ? T_W1_LOW : T_W0_LOW;
            end
          end
          PH_R_LOW: begin
            m_phase = PH_R_WAIT;
            m_cnt   = T_R_WAIT;
          end
          PH_R_WAIT: begin
            m_shift = {it.bus_sample, m_shift[7:1]};
            m_phase = PH_R_TAIL;
            m_cnt   = T_R_TAIL;
          end
          PH_R_TAIL: begin
            m_phase = PH_R_GAP;
            m_cnt   = T_GAP;
          end
          PH_R_GAP: begin
            if (m_bit == LAST_BIT) begin
              m_last_rd = m_shift;
              m_phase   = PH_IDLE;
              m_cnt     = '0;
              done      = 1'b1;
            end else begin
              m_bit   = m_bit + 3'd1;
              m_phase = PH_R_LOW;
              m_cnt   = T_R_LOW;
            end
          end
          default: begin
            m_phase = PH_IDLE;
            m_cnt   = '0;
          end
        endcase
      end
    end
    r.drive_low      = (m_phase == PH_RST_LOW) || (m_phase == PH_W_LOW) ||
                       (m_phase == PH_R_LOW);
    r.busy_res       = (m_phase != PH_IDLE);
    r.done_res       = done;
    r.device_present = m_present;
    r.read_data      = m_last_rd;
    r.cmd_rejected   = rej;
    return r;
  endfunction

  // Mostly short gaps, a few long ones; none at all in a quiet stretch
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Line level seen by the master: scripted on sampling ticks, noise elsewhere
  function automatic logic line_level(input logic s1, input logic s2,
                                      input logic [7:0] rd);
    if (m_cnt <= 9'd1) begin
      case (m_phase)
        PH_RST_W1: return s1;
        PH_RST_W2: return s2;
        PH_R_WAIT: return rd[m_bit];
        default: ;
      endcase
    end
    return 1'($urandom);
  endfunction

  function automatic req_t make_tick(input logic s);
    req_t it;
    it.req_type   = REQ_TICK;
    it.data_byte  = 8'($urandom);
    it.bus_sample = s;
    return it;
  endfunction

  // Present one request, wait for its transfer, log the predicted status
  task automatic send_item(input req_t it);
    int unsigned gap;
    gap = pick_gap(tx_quiet);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk_i); while (!req_if.ready);
    status_q.push_back(sequencer_step(it));
    item_cnt++;
    if (it.req_type != REQ_TICK) cmd_cnt++;
  endtask

  // Tick until the model is idle; noise_pm is the per-mille chance of a stray command
  task automatic drain_sequence(input logic s1, input logic s2, input logic [7:0] rd,
                                input int unsigned noise_pm);
    req_t it;
    while (m_phase != PH_IDLE) begin
      if ($urandom_range(0, 999) < noise_pm) begin
        it.req_type   = 2'($urandom_range(1, 3));
        it.data_byte  = 8'($urandom);
        it.bus_sample = 1'($urandom);
      end else begin
        it = make_tick(line_level(s1, s2, rd));
      end
      send_item(it);
    end
  endtask

  task automatic run_sequence(input req_e cmd, input logic [7:0] wr, input logic s1,
                              input logic s2, input logic [7:0] rd,
                              input int unsigned noise_pm);
    req_t it;
    it.req_type   = cmd;
    it.data_byte  = wr;
    it.bus_sample = 1'($urandom);
    send_item(it);
    seq_cnt++;
    drain_sequence(s1, s2, rd, noise_pm);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // Match one status transfer against the oldest prediction
  task automatic check_status(input res_t got);
    res_t want;
    xfer_cnt++;
    if (status_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10) $display("%0t: status %h with nothing pending", $time, got);
    end else begin
      want = status_q.pop_front();
      compare_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
      compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
      compare_field("device_present", 8'(want.device_present),
                    8'(got.device_present));
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("cmd_rejected", 8'(want.cmd_rejected), 8'(got.cmd_rejected));
      done_cnt   += want.done_res;
      reject_cnt += want.cmd_rejected;
    end
  endtask

  // Status sink: check each transfer, then stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        check_status(res_if.data);
        rx_stall = pick_gap(rx_quiet);
      end
      if ($urandom_range(0, 399) == 0) rx_quiet = !rx_quiet;
      if (rx_stall != 0) begin
        res_if.ready <= 1'b0;
        rx_stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Ticks with no sequence running change nothing
  task automatic test_idle_ticks();
    req_t it;
    for (int k = 0; k < 4; k++) begin
      it.req_type   = REQ_TICK;
      it.data_byte  = k[0] ? 8'hFF : 8'h00;
      it.bus_sample = k[1];
      send_item(it);
    end
  endtask

  // Every pair of sample levels, ending on a detected device
  task automatic test_reset_presence();
    run_sequence(REQ_RESET, 8'h00, 1'b0, 1'b1, 8'h00, 0);
    run_sequence(REQ_RESET, 8'hFF, 1'b0, 1'b0, 8'h00, 0);
    run_sequence(REQ_RESET, 8'h00, 1'b1, 1'b1, 8'h00, 0);
    run_sequence(REQ_RESET, 8'h00, 1'b1, 1'b0, 8'h00, 0);
    run_sequence(REQ_RESET, 8'h00, 1'b0, 1'b1, 8'h00, 0);
  endtask

  task automatic test_write_bytes();
    run_sequence(REQ_WRITE, 8'h00, 1'b0, 1'b0, 8'h00, 0);
    run_sequence(REQ_WRITE, 8'hFF, 1'b0, 1'b0, 8'h00, 0);
    run_sequence(REQ_WRITE, 8'h96, 1'b0, 1'b0, 8'h00, 0);
  endtask

  // Reads followed by idle ticks that must hold the assembled byte
  task automatic test_read_bytes();
    run_sequence(REQ_READ, 8'h00, 1'b0, 1'b0, 8'hFF, 0);
    run_sequence(REQ_READ, 8'hFF, 1'b0, 1'b0, 8'h00, 0);
    run_sequence(REQ_READ, 8'h00, 1'b0, 1'b0, 8'h69, 0);
    test_idle_ticks();
  endtask

  // Commands right behind an accepted one are dropped, all three kinds
  task automatic test_busy_reject();
    req_t it;
    it.data_byte  = 8'hA5;
    it.bus_sample = 1'b1;
    it.req_type   = REQ_READ;
    send_item(it);
    seq_cnt++;
    it.req_type = REQ_READ;
    send_item(it);
    it.req_type = REQ_RESET;
    send_item(it);
    it.req_type = REQ_WRITE;
    send_item(it);
    drain_sequence(1'b0, 1'b0, 8'hC3, 0);
    it.req_type = REQ_RESET;
    send_item(it);
    seq_cnt++;
    it.req_type  = REQ_WRITE;
    it.data_byte = 8'hFF;
    send_item(it);
    drain_sequence(1'b1, 1'b1, 8'h00, 0);
  endtask

  // Random sequences with stray commands until the item budget is spent
  task automatic test_random();
    int unsigned stop_at, kind;
    logic [7:0]  wr, rd;
    logic        s1, s2;
    stop_at = item_cnt + 750;
    while (item_cnt < stop_at) begin
      repeat ($urandom_range(0, 4)) send_item(make_tick(1'($urandom)));
      kind = $urandom_range(0, 7);
      wr   = (kind == 0) ? 8'h00 : (kind == 1) ? 8'hFF : 8'($urandom);
      kind = $urandom_range(0, 7);
      rd   = (kind == 0) ? 8'h00 : (kind == 1) ? 8'hFF : 8'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        s1 = 1'b0;
        s2 = 1'b1;
      end else begin
        s1 = 1'($urandom);
        s2 = 1'($urandom);
      end
      tx_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(1, 3))
        1:       run_sequence(REQ_RESET, wr, s1, s2, rd, 25);
        2:       run_sequence(REQ_WRITE, wr, s1, s2, rd, 25);
        default: run_sequence(REQ_READ, wr, s1, s2, rd, 25);
      endcase
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    res_if.ready = 1'b0;
    rst_ni       = 1'b0;
    rx_stall     = 0;
    rx_quiet     = 1'b0;
    tx_quiet     = 1'b0;
    m_phase      = PH_IDLE;
    m_cnt        = '0;
    m_bit        = '0;
    m_shift      = '0;
    m_first      = 1'b1;
    m_present    = 1'b0;
    m_last_rd    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_reset_presence();
    test_write_bytes();
    test_read_bytes();
    test_busy_reject();
    test_random();

    // Drop valid and let the last status transfers drain
    req_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d sequences, %0d items, %0d commands, %0d of them dropped while busy",
             seq_cnt, item_cnt, cmd_cnt, reject_cnt);
    $display("Checked %0d status transfers, %0d sequence completions, %0d mismatches",
             xfer_cnt, done_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
